// File: hw/rtl/pcda_pkg.sv
// pcda_pkg: shared types and constants for the pairwise column distance accumulator
// no dependencies; imported by the top level, both checkers and the testbench

package pcda_pkg;

	// fixed field widths of the item, result and register ports
	localparam int CELL_W    = 32;
	localparam int PIDX_W    = 9;
	localparam int TOTAL_W   = 48;
	localparam int METRIC_W  = 2;
	localparam int NCOL_W    = 6;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	// canberra quotient never exceeds 1.0 in Q.16, so 17 quotient bits suffice
	localparam int DIV_STEPS = 17;
	localparam int QUO_W     = 17;
	localparam int DCNT_W    = 5;

	typedef enum logic [1:0] {
		MET_MANHATTAN = 2'd0,
		MET_CANBERRA  = 2'd1,
		MET_BINARY    = 2'd2
	} metric_t;

	typedef enum logic [1:0] {
		REG_METRIC      = 2'd0,
		REG_CUTOFF      = 2'd1,
		REG_NUM_COLUMNS = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_TERM,
		S_DIV,
		S_ACC,
		S_DONE
	} state_t;

endpackage

// File: hw/rtl/pairwise_column_distance_accumulator_top.sv
// pairwise_column_distance_accumulator_top: upper-triangle column distance sums
// depends on pcda_pkg; holds the sequencer, the shared divider and both memories

// Usage: table cells stream in on the item channel (in_valid/in_stall), one cell per
// item with mode 0, row by row. The cell of column j is compared with the stored
// cells of columns 0..j-1 of its row and the selected metric is added to each pair
// sum. An item with mode 1 reads back one pair sum by its row-major pair number.
// Every item yields one result on out_valid/out_stall.
// A mode 1 read goes through S_READ and S_DONE to the output register. A cell of
// column j runs S_READ, S_TERM and S_ACC for each of its j pairs, plus S_DIV for
// each Canberra pair with a nonzero divisor; the pair loop is set by the single-port
// pair sum memory and the one radix-2 divider shared by all pairs. in_stall stays
// high until the result is loaded into the output register, which holds it while
// out_stall is high; the next item can be accepted while that result still waits.
// Reset: after arst_n releases, a clearing pass zeroes the pair sum memory, one
// entry a cycle, for MAX_COLUMNS*(MAX_COLUMNS-1)/2 entries (496 by default); items
// are held off during it, register writes are taken at any time.
// Writing num_columns restarts the current row; pair sums are kept.

module pairwise_column_distance_accumulator_top
	import pcda_pkg::*;
#(
	parameter int MAX_COLUMNS = 32,
	parameter int SUM_WIDTH   = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	// item channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                mode,
	input  logic [CELL_W-1:0]   cell_value,
	input  logic [PIDX_W-1:0]   pair_index,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [TOTAL_W-1:0]  pair_total,
	output logic                row_done,
	output logic                saturated,
	// register port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	localparam int PAIR_DEPTH = MAX_COLUMNS * (MAX_COLUMNS - 1) / 2;
	localparam int PI_W       = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
	localparam int CA         = $clog2(MAX_COLUMNS);
	localparam int NW         = $clog2(MAX_COLUMNS + 1);
	localparam int N_RST      = (MAX_COLUMNS < 32) ? MAX_COLUMNS : 32;
	localparam int PAIRS_RST  = N_RST * (N_RST - 1) / 2;

	// register file
	logic [METRIC_W-1:0]  metric_q;
	logic [CELL_W-1:0]    cutoff_q;
	logic [NCOL_W-1:0]    num_columns_q;
	logic [NW-1:0]        n_eff_q;
	logic [PI_W:0]        pairs_q;

	// sequencer and loop state
	state_t               state_q, state_d;
	logic [CA-1:0]        col_pos_q;
	logic [CA-1:0]        i_q;
	logic [CA-1:0]        j_q;
	logic [PI_W-1:0]      idx_q;
	logic [DCNT_W-1:0]    div_cnt_q;
	logic                 mode_q;
	logic                 hit_q;
	logic                 done_q;
	logic                 sat_q;
	logic                 out_valid_q;

	// payload registers
	logic [CELL_W-1:0]    cell_q;
	logic [CELL_W-1:0]    term_q;
	logic [32:0]          rem_q;
	logic [32:0]          den_q;
	logic                 diff0_q;
	logic [QUO_W-1:0]     quo_q;
	logic [TOTAL_W-1:0]   pair_total_q;
	logic                 row_done_q;
	logic                 saturated_q;

	// memories
	logic [SUM_WIDTH-1:0] pair_mem [PAIR_DEPTH];
	logic [SUM_WIDTH-1:0] pm_rdata_q;
	logic [CELL_W-1:0]    rc_mem [MAX_COLUMNS];
	logic [CELL_W-1:0]    rc_rdata_q;

	logic                 pm_we;
	logic [SUM_WIDTH-1:0] pm_wdata;
	logic                 rc_we;

	// combinational helpers
	logic                 in_acc;
	logic                 cfg_we;
	logic [CA-1:0]        j_cur;
	logic [NW:0]          j_plus;
	logic                 j_last;
	logic [NW-1:0]        n_new;
	logic [31:0]          pairs_new;
	logic                 idx_in_range;

	logic signed [32:0]   a_ext, b_ext, d_ext;
	logic [31:0]          abs_a, abs_b, diff;
	logic [32:0]          den;
	logic                 pres_a, pres_b;
	logic [CELL_W-1:0]    simple_term;

	logic [33:0]          div_shift;
	logic                 div_ge;
	logic                 div_bit;

	logic [SUM_WIDTH:0]   acc_sum;
	logic [SUM_WIDTH-1:0] acc_val;
	logic [PI_W-1:0]      idx_step;
	logic [63:0]          pm_ext;

	assign in_acc = in_valid && !in_stall;
	assign cfg_we = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	// ---------------- register port ----------------

	always_comb begin
		n_new = NW'(2);
		if (pwdata[NCOL_W-1:0] < NCOL_W'(2)) begin
			n_new = NW'(2);
		end else if (32'(pwdata[NCOL_W-1:0]) > 32'(MAX_COLUMNS)) begin
			n_new = NW'(MAX_COLUMNS);
		end else begin
			n_new = NW'(pwdata[NCOL_W-1:0]);
		end
		pairs_new = (32'(n_new) * (32'(n_new) - 32'd1)) >> 1;
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_METRIC:      prdata = PDATA_W'(metric_q);
			REG_CUTOFF:      prdata = cutoff_q;
			REG_NUM_COLUMNS: prdata = PDATA_W'(num_columns_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------- next state ----------------

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (idx_q == PI_W'(PAIR_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_acc) begin
					if (mode) begin
						state_d = S_READ;
					end else if (j_cur == '0) begin
						state_d = S_DONE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: state_d = mode_q ? S_DONE : S_TERM;
			S_TERM: begin
				if (metric_q == MET_CANBERRA && den != '0) begin
					state_d = S_DIV;
				end else begin
					state_d = S_ACC;
				end
			end
			S_DIV: begin
				if (div_cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				if (i_q == j_q - CA'(1)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_READ;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// ---------------- sequencer outputs ----------------

	always_comb begin
		in_stall = 1'b1;
		pm_we    = 1'b0;
		pm_wdata = acc_val;
		rc_we    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				pm_we    = 1'b1;
				pm_wdata = '0;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				rc_we    = in_valid && !mode;
			end
			S_ACC:   pm_we = 1'b1;
			default: ;
		endcase
	end

	// ---------------- datapath logic ----------------

	always_comb begin
		j_cur  = (NW'(col_pos_q) >= n_eff_q) ? '0 : col_pos_q;
		j_plus = (NW + 1)'(j_cur) + (NW + 1)'(1);
		j_last = j_plus >= (NW + 1)'(n_eff_q);
		idx_in_range = 32'(pair_index) < 32'(pairs_q);
	end

	// pair term from the stored cell (a) and the incoming cell (b)
	always_comb begin
		a_ext  = {rc_rdata_q[CELL_W-1], rc_rdata_q};
		b_ext  = {cell_q[CELL_W-1], cell_q};
		d_ext  = a_ext - b_ext;
		diff   = d_ext[32] ? 32'(-d_ext) : d_ext[31:0];
		abs_a  = a_ext[32] ? 32'(-a_ext) : a_ext[31:0];
		abs_b  = b_ext[32] ? 32'(-b_ext) : b_ext[31:0];
		den    = 33'(abs_a) + 33'(abs_b);
		pres_a = $signed(rc_rdata_q) > $signed(cutoff_q);
		pres_b = $signed(cell_q) > $signed(cutoff_q);
		case (metric_q)
			MET_MANHATTAN: simple_term = diff;
			MET_BINARY:    simple_term = (pres_a != pres_b) ? {15'd0, 1'b1, 16'd0} : '0;
			default:       simple_term = '0;
		endcase
	end

	// restoring divider step; only the first step brings in a nonzero numerator bit
	always_comb begin
		div_bit   = (div_cnt_q == '0) ? diff0_q : 1'b0;
		div_shift = {rem_q, div_bit};
		div_ge    = div_shift >= {1'b0, den_q};
	end

	always_comb begin
		acc_sum  = {1'b0, pm_rdata_q} + (SUM_WIDTH + 1)'(term_q);
		acc_val  = acc_sum[SUM_WIDTH] ? '1 : acc_sum[SUM_WIDTH-1:0];
		// distance between consecutive pair numbers of column j
		idx_step = PI_W'(n_eff_q) - PI_W'(2) - PI_W'(i_q);
		pm_ext   = 64'(pm_rdata_q);
	end

	// ---------------- control registers ----------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			metric_q      <= '0;
			cutoff_q      <= CELL_W'(32'h0001_0000);
			num_columns_q <= NCOL_W'(32);
			n_eff_q       <= NW'(N_RST);
			pairs_q       <= (PI_W + 1)'(PAIRS_RST);
			col_pos_q     <= '0;
			i_q           <= '0;
			j_q           <= '0;
			idx_q         <= '0;
			div_cnt_q     <= '0;
			mode_q        <= 1'b0;
			hit_q         <= 1'b0;
			done_q        <= 1'b0;
			sat_q         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (paddr[3:2])
					REG_METRIC:  metric_q <= pwdata[METRIC_W-1:0];
					REG_CUTOFF:  cutoff_q <= pwdata;
					REG_NUM_COLUMNS: begin
						num_columns_q <= pwdata[NCOL_W-1:0];
						n_eff_q       <= n_new;
						pairs_q       <= (PI_W + 1)'(pairs_new);
						col_pos_q     <= '0;
					end
					default: ;
				endcase
			end

			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: idx_q <= idx_q + PI_W'(1);
				S_IDLE: begin
					if (in_acc) begin
						mode_q <= mode;
						sat_q  <= 1'b0;
						i_q    <= '0;
						if (mode) begin
							idx_q  <= PI_W'(pair_index);
							hit_q  <= idx_in_range;
							done_q <= 1'b0;
						end else begin
							j_q       <= j_cur;
							idx_q     <= PI_W'(j_cur) - PI_W'(1);
							hit_q     <= 1'b0;
							done_q    <= j_last;
							col_pos_q <= j_last ? '0 : CA'(j_plus);
						end
					end
				end
				S_TERM:  div_cnt_q <= '0;
				S_DIV:   div_cnt_q <= div_cnt_q + DCNT_W'(1);
				S_ACC: begin
					sat_q <= sat_q | acc_sum[SUM_WIDTH];
					i_q   <= i_q + CA'(1);
					idx_q <= idx_q + idx_step;
				end
				default: ;
			endcase
		end
	end

	// ---------------- payload registers ----------------

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cell_q <= cell_value;
		end
		if (state_q == S_TERM) begin
			term_q  <= simple_term;
			rem_q   <= 33'(diff >> 1);
			den_q   <= den;
			diff0_q <= diff[0];
			quo_q   <= '0;
		end
		if (state_q == S_DIV) begin
			rem_q <= div_ge ? 33'(div_shift - {1'b0, den_q}) : div_shift[32:0];
			quo_q <= {quo_q[QUO_W-2:0], div_ge};
			if (div_cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
				term_q <= CELL_W'({quo_q[QUO_W-2:0], div_ge});
			end
		end
		if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			pair_total_q <= (mode_q && hit_q) ? pm_ext[TOTAL_W-1:0] : '0;
			row_done_q   <= done_q;
			saturated_q  <= sat_q;
		end
	end

	// ---------------- memories ----------------

	always_ff @(posedge clk) begin
		if (pm_we) begin
			pair_mem[idx_q] <= pm_wdata;
		end
		pm_rdata_q <= pair_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (rc_we) begin
			rc_mem[j_cur] <= cell_value;
		end
		rc_rdata_q <= rc_mem[i_q];
	end

	assign out_valid  = out_valid_q;
	assign pair_total = pair_total_q;
	assign row_done   = row_done_q;
	assign saturated  = saturated_q;

endmodule

// File: hw/rtl/pcda_checker.sv
// pcda_checker: port-level assertions for the pairwise column distance accumulator
// depends on pcda_pkg; bound to pairwise_column_distance_accumulator_top below

module pcda_checker
	import pcda_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [TOTAL_W-1:0] pair_total,
	input logic               row_done,
	input logic               saturated
);

	// a held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pair_total) && $stable(row_done)
			&& $stable(saturated))
		else $error("result changed while stalled");

	// cell results that flag row_done or saturated never carry a pair total
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (row_done || saturated) |-> pair_total == '0)
		else $error("cell result with nonzero pair total");

	// one item at a time: busy right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while busy");

	// a new result only comes out of a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");

endmodule

bind pairwise_column_distance_accumulator_top pcda_checker u_pcda_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.pair_total (pair_total),
	.row_done   (row_done),
	.saturated  (saturated)
);

// File: verif/pcda_distance_checker.sv
// pcda_distance_checker: watches the register port, the item and result channels of the pair
// distance accumulator, predicts every result and compares it; depends on pcda_pkg

module pcda_distance_checker
	import pcda_pkg::*;
#(
	parameter int MAX_COLUMNS = 32,
	parameter int SUM_WIDTH   = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               mode,
	input  logic [CELL_W-1:0]  cell_value,
	input  logic [PIDX_W-1:0]  pair_index,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [TOTAL_W-1:0] pair_total,
	input  logic               row_done,
	input  logic               saturated,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 fail_count,
	output int                 pending,
	output int                 results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAIR_DEPTH = MAX_COLUMNS * (MAX_COLUMNS - 1) / 2;
	localparam longint unsigned SUM_MAX = (64'd1 << SUM_WIDTH) - 64'd1;

	typedef struct {
		logic [TOTAL_W-1:0] total;
		logic               done;
		logic               sat;
	} pcda_result_t;

	pcda_result_t expected_results[$];

	// shadow of the block's registers and memories
	logic [METRIC_W-1:0] metric_sel;
	logic [CELL_W-1:0]   cutoff_q;
	logic [NCOL_W-1:0]   ncol_q;
	logic [CELL_W-1:0]   row_cells[MAX_COLUMNS];
	longint unsigned     pair_sums[PAIR_DEPTH];
	int unsigned         col_pos;

	function automatic void clear_model();
		int k;
		metric_sel = MET_MANHATTAN;
		cutoff_q   = 32'h0001_0000;
		ncol_q     = 6'd32;
		col_pos    = 0;
		for (k = 0; k < MAX_COLUMNS; k++)
			row_cells[k] = '0;
		for (k = 0; k < PAIR_DEPTH; k++)
			pair_sums[k] = 64'd0;
	endfunction

	function automatic int unsigned live_columns();
		int unsigned n;
		n = 32'(ncol_q);
		if (n < 2)
			n = 2;
		if (n > MAX_COLUMNS)
			n = MAX_COLUMNS;
		return n;
	endfunction

	function automatic longint unsigned distance_term(input logic [CELL_W-1:0] left,
			input logic [CELL_W-1:0] right);
		longint a;
		longint b;
		longint c;
		longint d;
		longint unsigned diff;
		longint unsigned den;
		a = longint'($signed(left));
		b = longint'($signed(right));
		c = longint'($signed(cutoff_q));
		d = a - b;
		if (d < 0)
			d = -d;
		diff = d;
		case (metric_sel)
			MET_MANHATTAN: return diff;
			MET_CANBERRA: begin
				den = ((a < 0) ? -a : a) + ((b < 0) ? -b : b);
				if (den == 0)
					return 64'd0;
				return (diff << 16) / den;
			end
			MET_BINARY: return ((a > c) != (b > c)) ? 64'd65536 : 64'd0;
			default: return 64'd0;
		endcase
	endfunction

	function automatic pcda_result_t predict_item(input logic m, input logic [CELL_W-1:0] v,
			input logic [PIDX_W-1:0] p);
		pcda_result_t r;
		int unsigned n;
		int unsigned i;
		int unsigned j;
		int unsigned idx;
		longint unsigned d;
		n = live_columns();
		r.total = '0;
		r.done  = 1'b0;
		r.sat   = 1'b0;
		if (!m) begin
			j = (col_pos >= n) ? 0 : col_pos;
			for (i = 0; i < j; i++) begin
				idx = i * (2 * n - i - 1) / 2 + (j - i - 1);
				if (idx < PAIR_DEPTH) begin
					d = distance_term(row_cells[i], v);
					if (pair_sums[idx] > SUM_MAX - d) begin
						pair_sums[idx] = SUM_MAX;
						r.sat = 1'b1;
					end else begin
						pair_sums[idx] += d;
					end
				end
			end
			row_cells[j] = v;
			if (j + 1 >= n) begin
				col_pos = 0;
				r.done  = 1'b1;
			end else begin
				col_pos = j + 1;
			end
		end else if (p < n * (n - 1) / 2 && p < PAIR_DEPTH) begin
			r.total = TOTAL_W'(pair_sums[p]);
		end
		return r;
	endfunction

	function automatic void apply_write(input logic [PADDR_W-3:0] idx,
			input logic [PDATA_W-1:0] data);
		case (idx)
			REG_METRIC:  metric_sel = data[METRIC_W-1:0];
			REG_CUTOFF:  cutoff_q = data[CELL_W-1:0];
			REG_NUM_COLUMNS: begin
				ncol_q  = data[NCOL_W-1:0];
				col_pos = 0;
			end
			default: ;
		endcase
	endfunction

	function automatic void report_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		fail_count++;
		$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
	endfunction

	function automatic void check_result();
		pcda_result_t want;
		results_checked++;
		if (expected_results.size() == 0) begin
			fail_count++;
			$display("%0t: result with none expected, expected nothing actual %0h/%0b/%0b",
				$time, pair_total, row_done, saturated);
		end else begin
			want = expected_results.pop_front();
			pending--;
			if (pair_total !== want.total)
				report_field("pair_total", 64'(want.total), 64'(pair_total));
			if (row_done !== want.done)
				report_field("row_done", 64'(want.done), 64'(row_done));
			if (saturated !== want.sat)
				report_field("saturated", 64'(want.sat), 64'(saturated));
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			expected_results.delete();
			fail_count      = 0;
			pending         = 0;
			results_checked = 0;
		end else begin
			if (psel && penable && pwrite && pready)
				apply_write(paddr[PADDR_W-1:2], pwdata);
			// the result leaving now belongs to an older item than one entering now
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_item(mode, cell_value, pair_index));
				pending++;
			end
		end
	end

endmodule

// File: verif/pairwise_column_distance_accumulator_top_tb.sv
// pairwise_column_distance_accumulator_top_tb: stimulus, idling and verdict for the pair
// distance accumulator; depends on pcda_pkg, the block and pcda_distance_checker

module pairwise_column_distance_accumulator_top_tb
	import pcda_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 42;
	localparam int LONG_HOLD   = 400;
	localparam int TAIL_CYCLES = 100;
	localparam int CYCLE_LIMIT = 3_000_000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic mode;
	logic [CELL_W-1:0]  cell_value;
	logic [PIDX_W-1:0]  pair_index;
	logic out_valid;
	logic out_stall;
	logic [TOTAL_W-1:0] pair_total;
	logic row_done;
	logic saturated;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	int fail_count;
	int pending;
	int results_checked;

	// handshakes seen at the last rising edge, read back at the falling edge
	logic in_taken  = 1'b0;
	logic reg_taken = 1'b0;

	bit rx_hold_req = 1'b0;
	bit rx_quiet    = 1'b0;

	logic [CELL_W-1:0] cur_cutoff = 32'h0001_0000;
	int cur_ncol  = 32;
	int cells_sent;
	int reads_sent;
	int reg_writes;

	always #1 clk = ~clk;

	always @(posedge clk) begin
		in_taken  <= in_valid && !in_stall;
		reg_taken <= psel && penable && pwrite && pready;
	end

	pairwise_column_distance_accumulator_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.cell_value (cell_value),
		.pair_index (pair_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pair_total (pair_total),
		.row_done   (row_done),
		.saturated  (saturated),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	pcda_distance_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.cell_value      (cell_value),
		.pair_index      (pair_index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pair_total      (pair_total),
		.row_done        (row_done),
		.saturated       (saturated),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	// mostly no gap, often a short one, now and then a long one
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 12)
			return 0;
		if (roll < 19)
			return $urandom_range(1, 4);
		return $urandom_range(12, 60);
	endfunction

	function automatic logic [CELL_W-1:0] pick_cell();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return cur_cutoff + 32'($urandom_range(0, 4)) - 32'd2;
			4: return (32'($urandom_range(0, 40)) << 16) - 32'h0014_0000;
			5: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [PIDX_W-1:0] pick_pair();
		int n;
		n = (cur_ncol < 2) ? 2 : ((cur_ncol > 32) ? 32 : cur_ncol);
		if ($urandom_range(0, 9) < 7)
			return PIDX_W'($urandom_range(0, n * (n - 1) / 2 - 1));
		return PIDX_W'($urandom_range(0, 511));
	endfunction

	// called at a falling edge; returns at the falling edge after the item was taken
	task automatic put_item(input logic m, input logic [CELL_W-1:0] c,
			input logic [PIDX_W-1:0] p, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		cell_value <= c;
		pair_index <= p;
		do begin
			@(negedge clk);
		end while (!in_taken);
		if (m)
			reads_sent++;
		else
			cells_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (pending != 0);
	endtask

	task automatic write_reg(input reg_idx_t r, input logic [PDATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
		end while (!reg_taken);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		if (r == REG_CUTOFF)
			cur_cutoff = v;
		if (r == REG_NUM_COLUMNS)
			cur_ncol = int'(v[NCOL_W-1:0]);
		reg_writes++;
	endtask

	// receiver side: random stalls, quiet stretches, and one long hold on request
	initial begin : rx_side
		int stall_n;
		out_stall <= 1'b0;
		@(negedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				stall_n = rx_quiet ? 0 : idle_len();
				if (stall_n > 0) begin
					out_stall <= 1'b1;
					repeat (stall_n) @(negedge clk);
				end
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int k;
		int gap;
		int ncol;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		mode       <= 1'b0;
		cell_value <= '0;
		pair_index <= '0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		cells_sent = 0;
		reads_sent = 0;
		reg_writes = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// manhattan on three columns, full-scale difference, reads in and out of range
		write_reg(REG_METRIC, PDATA_W'(MET_MANHATTAN));
		write_reg(REG_NUM_COLUMNS, 32'd3);
		put_item(1'b1, 32'hFFFF_FFFF, 9'd0, 0);
		put_item(1'b0, 32'h7FFF_FFFF, 9'h1FF, 0);
		put_item(1'b0, 32'h8000_0000, 9'd0, 0);
		put_item(1'b0, 32'h0000_0000, 9'd0, 0);
		put_item(1'b1, 32'h0, 9'd0, 0);
		put_item(1'b1, 32'h0, 9'd2, 0);
		put_item(1'b1, 32'h0, 9'd3, 0);
		put_item(1'b1, 32'h0, 9'h1FF, 0);

		// canberra with a zero divisor, then with signed extremes
		wait_drained();
		write_reg(REG_METRIC, PDATA_W'(MET_CANBERRA));
		write_reg(REG_NUM_COLUMNS, 32'd3);
		put_item(1'b0, 32'h0000_0000, 9'd0, 0);
		put_item(1'b0, 32'h0000_0000, 9'd0, 0);
		put_item(1'b0, 32'h0001_0000, 9'd0, 0);
		put_item(1'b0, 32'h8000_0000, 9'd0, 1);
		put_item(1'b0, 32'h7FFF_FFFF, 9'd0, 0);
		put_item(1'b0, 32'hFFFF_FFFF, 9'd0, 0);
		put_item(1'b1, 32'h0, 9'd0, 0);
		put_item(1'b1, 32'h0, 9'd2, 0);

		// binary with the lowest and the highest cutoff
		wait_drained();
		write_reg(REG_METRIC, PDATA_W'(MET_BINARY));
		write_reg(REG_CUTOFF, 32'h8000_0000);
		write_reg(REG_NUM_COLUMNS, 32'd2);
		put_item(1'b0, 32'h8000_0000, 9'd0, 0);
		put_item(1'b0, 32'h8000_0001, 9'd0, 0);
		wait_drained();
		write_reg(REG_CUTOFF, 32'h7FFF_FFFF);
		put_item(1'b0, 32'h7FFF_FFFF, 9'd0, 0);
		put_item(1'b0, 32'h8000_0000, 9'd0, 0);
		put_item(1'b1, 32'h0, 9'd0, 0);

		// unused metric, column count below range, row restart by a count write
		wait_drained();
		write_reg(REG_METRIC, 32'd3);
		write_reg(REG_NUM_COLUMNS, 32'd0);
		put_item(1'b0, 32'h0005_0000, 9'd0, 0);
		wait_drained();
		write_reg(REG_NUM_COLUMNS, 32'd1);
		put_item(1'b0, 32'h0007_0000, 9'd0, 0);
		put_item(1'b0, 32'h0009_0000, 9'd0, 0);
		put_item(1'b1, 32'h0, 9'd0, 0);

		for (phase = 0; phase < PHASES; phase++) begin
			// every setting change waits until the block has no item in flight
			wait_drained();
			write_reg(REG_METRIC, (phase < 4) ? phase : $urandom_range(0, 3));
			case ($urandom_range(0, 3))
				0: write_reg(REG_CUTOFF, 32'h7FFF_FFFF);
				1: write_reg(REG_CUTOFF, 32'h8000_0000);
				2: write_reg(REG_CUTOFF, 32'h0000_0000);
				default: write_reg(REG_CUTOFF, $urandom());
			endcase
			case (phase)
				1: ncol = 32;
				5: ncol = 63;
				6: ncol = 0;
				7: ncol = 1;
				9: ncol = 40;
				default: ncol = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 32)
					: $urandom_range(2, 8);
			endcase
			// some phases keep the row that was in progress
			if (phase != 8 && phase != 11)
				write_reg(REG_NUM_COLUMNS, ncol);
			rx_quiet = (phase == 4);
			if (phase == 3)
				rx_hold_req = 1'b1;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				gap = (phase == 3 || phase == 4) ? 0 : idle_len();
				if ($urandom_range(0, 4) == 0)
					put_item(1'b1, $urandom(), pick_pair(), gap);
				else
					put_item(1'b0, pick_cell(), PIDX_W'($urandom()), gap);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("sent %0d cells and %0d pair reads over %0d register writes, %0d results checked",
			cells_sent, reads_sent, reg_writes, results_checked);
		$display("all four metric codes, column counts 0 to 63, long output hold and drains");
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
